@@ design/csdf_pkg.sv @@
package csdf_pkg;

  localparam logic [7:0] START_BYTE = 8'hFD;
  localparam logic [7:0] END_BYTE   = 8'hBF;
  localparam logic [3:0] MAX_LEN    = 4'd8;

  localparam int unsigned DATA_BYTES = 8;
  localparam int unsigned MATCH_W    = 4;
  localparam int unsigned ENTRY_W    = 24;
  localparam int unsigned ID_W       = 12;
  localparam int unsigned LEN_W      = 4;
  localparam int unsigned COUNT_W    = 3;
  localparam int unsigned ADDR_W     = 5;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned REG_IDX_W  = 3;

  // Frame queue between parser and filter stage
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_AW    = 1;
  localparam int unsigned Q_CW    = 2;

  localparam logic [REG_IDX_W-1:0] REG_FILTER_COUNT = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ENTRY_BASE   = 3'd1;

  typedef enum logic [4:0] {
    PH_HUNT   = 5'b00001,
    PH_HEADER = 5'b00010,
    PH_IDLOW  = 5'b00100,
    PH_DATA   = 5'b01000,
    PH_END    = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [ID_W-1:0]           id;
    logic [LEN_W-1:0]          length;
    logic [DATA_BYTES-1:0][7:0] data;
  } frame_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

@@ design/csdf_parser.sv @@
module csdf_parser
  import csdf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_valid,
  input  logic [7:0] rx_byte,
  output logic       frame_valid,
  output frame_t     frame
);

  phase_t                     phase_r, phase_nxt;
  logic [LEN_W-1:0]           left_r, left_nxt;
  logic [LEN_W-1:0]           len_r, len_nxt;
  logic [ID_W-1:0]            id_r, id_nxt;
  logic [DATA_BYTES-1:0][7:0] data_r, data_nxt;
  logic [LEN_W-1:0]           left_dec;
  logic [2:0]                 pos;

  assign left_dec = left_r - 4'd1;
  assign pos      = len_r[2:0] - left_r[2:0];

  always_comb begin
    phase_nxt   = phase_r;
    left_nxt    = left_r;
    len_nxt     = len_r;
    id_nxt      = id_r;
    data_nxt    = data_r;
    frame_valid = 1'b0;
    unique case (phase_r)
      PH_HEADER: begin
        if (rx_byte[7:4] > MAX_LEN) begin
          phase_nxt = PH_HUNT;
        end else begin
          len_nxt   = rx_byte[7:4];
          id_nxt    = {rx_byte[3:0], 8'h00};
          phase_nxt = PH_IDLOW;
        end
      end
      PH_IDLOW: begin
        id_nxt    = {id_r[ID_W-1:8], rx_byte};
        left_nxt  = len_r;
        phase_nxt = (len_r == '0) ? PH_END : PH_DATA;
      end
      PH_DATA: begin
        data_nxt[pos] = rx_byte;
        left_nxt = left_dec;
        if (left_dec == '0) begin
          phase_nxt = PH_END;
        end
      end
      PH_END: begin
        frame_valid = byte_valid && (rx_byte == END_BYTE);
        phase_nxt   = PH_HUNT;
      end
      default: begin
        phase_nxt = (rx_byte == START_BYTE) ? PH_HEADER : PH_HUNT;
      end
    endcase
  end

  assign frame.id     = id_r;
  assign frame.length = len_r;
  assign frame.data   = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      left_r  <= '0;
      len_r   <= '0;
      id_r    <= '0;
      data_r  <= '0;
    end else if (byte_valid) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      len_r   <= len_nxt;
      id_r    <= id_nxt;
      data_r  <= data_nxt;
    end
  end

endmodule

@@ design/csdf_queue.sv @@
module csdf_queue
  import csdf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_en,
  input  frame_t    wr_frame,
  input  logic      rd_en,
  output frame_t    rd_frame,
  output q_status_t status
);

  frame_t          mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r;
  logic [Q_AW-1:0] rd_ptr_r;
  logic [Q_CW-1:0] count_r;
  logic            do_wr;
  logic            do_rd;

  assign status.full  = (count_r == Q_CW'(Q_DEPTH));
  assign status.empty = (count_r == '0);
  assign do_wr        = wr_en && !status.full;
  assign do_rd        = rd_en && !status.empty;
  assign rd_frame     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

@@ design/csdf_filter.sv @@
module csdf_filter
  import csdf_pkg::*;
#(
  parameter int unsigned FILTER_ENTRIES = 4
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic [COUNT_W-1:0]                      filter_count,
  input  logic [FILTER_ENTRIES-1:0][ENTRY_W-1:0]  filter_entry,
  input  logic                                    q_empty,
  input  frame_t                                  q_frame,
  output logic                                    q_pop,
  output logic                                    out_valid,
  input  logic                                    out_take,
  output frame_t                                  out_frame,
  output logic [MATCH_W-1:0]                      out_match
);

  logic                 valid_r;
  frame_t               frame_r;
  logic [MATCH_W-1:0]   match_r;
  logic [MATCH_W-1:0]   match_nxt;
  logic [ID_W-1:0]      id_mask;
  logic [ID_W-1:0]      id_value;

  always_comb begin
    match_nxt = '0;
    id_mask   = '0;
    id_value  = '0;
    for (int i = 0; i < FILTER_ENTRIES; i++) begin
      id_mask  = filter_entry[i][ENTRY_W-1:ID_W];
      id_value = filter_entry[i][ID_W-1:0];
      if ((COUNT_W'(i) < filter_count) && ((q_frame.id & id_mask) == id_value)) begin
        match_nxt[i] = 1'b1;
      end
    end
  end

  // Refill the output register when it is free or being drained
  assign q_pop     = !q_empty && (!valid_r || out_take);
  assign out_valid = valid_r;
  assign out_frame = frame_r;
  assign out_match = match_r;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      frame_r <= q_frame;
      match_r <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (out_take) begin
      valid_r <= 1'b0;
    end
  end

endmodule

@@ design/can_serial_frame_deframer_filter_core.sv @@
// Channel   Handshake            Payload
// input     push / full          in_rx_byte
// result    pop / empty          out_frame_id, out_frame_length, out_frame_data,
//                                out_match_mask
// config    psel/penable/pwrite  paddr, pwdata, prdata, pready
//
// One byte is taken per cycle while full is low; an accepted end byte writes
// the frame to the queue, which refills the output register when it is free.
// A two-entry frame queue sits between the byte parser and the filter stage.
// Synchronous reset clears parse state, filter registers, queue and output valid.
// full rises only with two frames queued; a low pop keeps the output register.
module can_serial_frame_deframer_filter_core
  import csdf_pkg::*;
#(
  parameter int unsigned FILTER_ENTRIES = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         in_rx_byte,
  output logic               empty,
  input  logic               pop,
  output logic [ID_W-1:0]    out_frame_id,
  output logic [LEN_W-1:0]   out_frame_length,
  output logic [63:0]        out_frame_data,
  output logic [MATCH_W-1:0] out_match_mask,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  logic [COUNT_W-1:0]                     count_r;
  logic [FILTER_ENTRIES-1:0][ENTRY_W-1:0] entry_r;
  logic [REG_IDX_W-1:0]                   reg_idx;
  logic                                   cfg_wr;
  logic                                   byte_acc;
  logic                                   frame_valid;
  frame_t                                 frame;
  frame_t                                 q_frame;
  q_status_t                              q_status;
  logic                                   q_pop;
  logic                                   out_valid;
  frame_t                                 out_frame;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      entry_r <= '0;
    end else if (cfg_wr) begin
      if (reg_idx == REG_FILTER_COUNT) begin
        count_r <= pwdata[COUNT_W-1:0];
      end
      for (int i = 0; i < FILTER_ENTRIES; i++) begin
        if (reg_idx == REG_IDX_W'(REG_ENTRY_BASE + i)) begin
          entry_r[i] <= pwdata[ENTRY_W-1:0];
        end
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_FILTER_COUNT) begin
      prdata = DATA_W'(count_r);
    end
    for (int i = 0; i < FILTER_ENTRIES; i++) begin
      if (reg_idx == REG_IDX_W'(REG_ENTRY_BASE + i)) begin
        prdata = DATA_W'(entry_r[i]);
      end
    end
  end

  assign full     = q_status.full;
  assign byte_acc = push && !full;

  csdf_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_valid  (byte_acc),
    .rx_byte     (in_rx_byte),
    .frame_valid (frame_valid),
    .frame       (frame)
  );

  csdf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (frame_valid),
    .wr_frame (frame),
    .rd_en    (q_pop),
    .rd_frame (q_frame),
    .status   (q_status)
  );

  csdf_filter #(
    .FILTER_ENTRIES (FILTER_ENTRIES)
  ) u_filter (
    .clk          (clk),
    .rst_n        (rst_n),
    .filter_count (count_r),
    .filter_entry (entry_r),
    .q_empty      (q_status.empty),
    .q_frame      (q_frame),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_take     (pop),
    .out_frame    (out_frame),
    .out_match    (out_match_mask)
  );

  assign empty            = !out_valid;
  assign out_frame_id     = out_frame.id;
  assign out_frame_length = out_frame.length;
  assign out_frame_data   = out_frame.data;

`ifndef ASSERT_OFF
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    frame_valid |-> !q_status.full)
    else $error("frame queue overflow");

  a_queue_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_status.empty)
    else $error("pop from empty frame queue");

  a_pop_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> !empty)
    else $error("queued frame lost on its way to the output");

  a_match_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> ((out_match_mask >> FILTER_ENTRIES) == '0))
    else $error("match bit set beyond the filter entries");
`endif

endmodule

@@ sim/tb_can_serial_frame_deframer_filter_core.sv @@
`timescale 1ns / 1ps

module tb_can_serial_frame_deframer_filter_core
  import csdf_pkg::*;
();

  localparam int unsigned ENTRIES      = 4;
  localparam int unsigned ITEM_TARGET  = 1900;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  typedef struct {
    logic [ID_W-1:0]    id;
    logic [LEN_W-1:0]   length;
    logic [63:0]        data;
    logic [MATCH_W-1:0] match_bits;
  } frame_result_t;

  logic               clk;
  logic               rst_n;
  logic               push;
  logic               full;
  logic [7:0]         in_rx_byte;
  logic               empty;
  logic               pop;
  logic [ID_W-1:0]    out_frame_id;
  logic [LEN_W-1:0]   out_frame_length;
  logic [63:0]        out_frame_data;
  logic [MATCH_W-1:0] out_match_mask;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  // Predictor state: parser and filter registers
  phase_t             parse_ph;
  logic [3:0]         bytes_due;
  logic [3:0]         frame_len;
  logic [ID_W-1:0]    frame_ident;
  logic [7:0]         frame_bytes [DATA_BYTES];
  logic [COUNT_W-1:0] filt_count;
  logic [ENTRY_W-1:0] filt_entry [ENTRIES];

  frame_result_t frames_due[$];
  int unsigned   mismatch_count;
  int unsigned   bytes_sent;
  int unsigned   cycle_count;
  int unsigned   hold_left;
  bit            hold_req;
  bit            tx_gaps_on;
  bit            rx_gaps_on;

  can_serial_frame_deframer_filter_core #(.FILTER_ENTRIES(ENTRIES)) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_rx_byte       (in_rx_byte),
    .empty            (empty),
    .pop              (pop),
    .out_frame_id     (out_frame_id),
    .out_frame_length (out_frame_length),
    .out_frame_data   (out_frame_data),
    .out_match_mask   (out_match_mask),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic logic [MATCH_W-1:0] filter_hits(input logic [ID_W-1:0] id);
    logic [MATCH_W-1:0] hits;
    int unsigned        n;
    hits = '0;
    n = (filt_count > ENTRIES) ? ENTRIES : filt_count;
    for (int i = 0; i < n; i++) begin
      if ((id & filt_entry[i][23:12]) == filt_entry[i][11:0]) hits[i] = 1'b1;
    end
    return hits;
  endfunction

  // Advance the parser model by one accepted byte; queue a frame on a good end byte
  task automatic deframe_predict(input logic [7:0] b);
    frame_result_t fr;
    logic [2:0]    pos;
    case (parse_ph)
      PH_HEADER: begin
        if (b[7:4] > MAX_LEN) begin
          parse_ph = PH_HUNT;
        end else begin
          frame_len   = b[7:4];
          frame_ident = {b[3:0], 8'h00};
          parse_ph    = PH_IDLOW;
        end
      end
      PH_IDLOW: begin
        frame_ident[7:0] = b;
        bytes_due        = frame_len;
        parse_ph         = (frame_len == 0) ? PH_END : PH_DATA;
      end
      PH_DATA: begin
        pos              = 3'(frame_len - bytes_due);
        frame_bytes[pos] = b;
        bytes_due        = bytes_due - 4'd1;
        if (bytes_due == 0) parse_ph = PH_END;
      end
      PH_END: begin
        if (b == END_BYTE) begin
          fr.id         = frame_ident;
          fr.length     = frame_len;
          for (int k = 0; k < DATA_BYTES; k++) fr.data[8*k +: 8] = frame_bytes[k];
          fr.match_bits = filter_hits(frame_ident);
          frames_due.push_back(fr);
        end
        parse_ph = PH_HUNT;
      end
      default: parse_ph = (b == START_BYTE) ? PH_HEADER : PH_HUNT;
    endcase
  endtask

  // Entered and left at a falling edge; push stays high for a following transaction
  task automatic send_byte(input logic [7:0] b);
    if (tx_gaps_on) begin
      while ($urandom_range(99) < 35) begin
        push <= 1'b0;
        @(negedge clk);
      end
    end
    push       <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (full);
    deframe_predict(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(input logic [ID_W-1:0] id, input logic [3:0] len,
                            input logic [7:0] tail);
    send_byte(START_BYTE);
    send_byte({len, id[11:8]});
    send_byte(id[7:0]);
    for (int k = 0; k < len; k++) send_byte(8'($urandom));
    send_byte(tail);
  endtask

  // Bias ids toward the programmed entries so matches actually occur
  function automatic logic [ID_W-1:0] pick_id();
    logic [ID_W-1:0] mask;
    int unsigned     e;
    if ($urandom_range(1) == 0) return 12'($urandom);
    e    = $urandom_range(ENTRIES - 1);
    mask = filt_entry[e][23:12];
    return (filt_entry[e][11:0] & mask) | (12'($urandom) & ~mask);
  endfunction

  task automatic send_good_frame();
    send_frame(pick_id(), 4'($urandom_range(MAX_LEN)), END_BYTE);
  endtask

  task automatic drain_results();
    push <= 1'b0;
    while (frames_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_FILTER_COUNT) filt_count = val[COUNT_W-1:0];
    else if (idx < REG_ENTRY_BASE + ENTRIES) filt_entry[idx - REG_ENTRY_BASE] = val[ENTRY_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Rotate entry styles so pass-all, exact-FFF, raw random and clean masks all appear
  task automatic program_filters(input logic [COUNT_W-1:0] count, input int unsigned round);
    logic [11:0] mask;
    logic [31:0] val;
    drain_results();
    write_reg(REG_FILTER_COUNT, {$urandom_range(1) ? 29'($urandom) : 29'd0, count});
    for (int e = 0; e < ENTRIES; e++) begin
      mask = 12'($urandom);
      case ((e + round) % 4)
        0:       val = 32'h0000_0000;
        1:       val = 32'h00FF_FFFF;
        2:       val = $urandom;
        default: val = {8'h00, mask, 12'($urandom) & mask};
      endcase
      write_reg(REG_IDX_W'(REG_ENTRY_BASE + e), val);
    end
    // Addresses past the register list must be ignored
    write_reg(REG_IDX_W'($urandom_range(7, REG_ENTRY_BASE + ENTRIES)), $urandom);
  endtask

  task automatic test_directed_frames();
    logic [7:0] script [$];
    script = {8'h00, 8'hFF,
              // zero length, all-ones id
              START_BYTE, 8'h0F, 8'hFF, END_BYTE,
              // length above eight; that header is not a new start
              START_BYTE, START_BYTE,
              // full length with start and end values inside
              START_BYTE, 8'h80, END_BYTE, START_BYTE, END_BYTE, 8'h00, 8'hFF,
              8'h01, 8'h02, 8'h03, 8'h04, END_BYTE,
              // wrong end byte drops the frame but leaves its data behind
              START_BYTE, 8'h10, 8'h00, 8'h55, 8'h00};
    foreach (script[i]) send_byte(script[i]);
    // a short frame afterward shows the stale bytes
    send_frame(12'h000, 4'd1, END_BYTE);
  endtask

  task automatic test_filter_settings();
    logic [COUNT_W-1:0] counts [8];
    counts = '{3'd0, 3'd4, 3'd7, 3'd1, 3'd5, 3'd2, 3'd3, 3'd6};
    foreach (counts[i]) begin
      program_filters(counts[i], i);
      repeat (10) send_good_frame();
    end
  endtask

  task automatic test_no_idle_stretch();
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    repeat (25) send_good_frame();
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  task automatic test_backpressure();
    tx_gaps_on = 1'b0;
    hold_req   = 1'b1;
    repeat (30) send_frame(pick_id(), 4'($urandom_range(2)), END_BYTE);
    tx_gaps_on = 1'b1;
  endtask

  task automatic test_random_stream();
    int unsigned pick;
    int unsigned round;
    round = 0;
    while (bytes_sent < ITEM_TARGET) begin
      if (bytes_sent / 300 != round) begin
        round = bytes_sent / 300;
        program_filters(COUNT_W'($urandom), round);
      end
      pick = $urandom_range(99);
      if (pick < 78) begin
        send_good_frame();
      end else if (pick < 86) begin
        send_frame(pick_id(), 4'($urandom_range(MAX_LEN)), 8'($urandom));
      end else if (pick < 93) begin
        send_byte(START_BYTE);
        send_byte({4'($urandom_range(15, MAX_LEN + 1)), 4'($urandom)});
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Compare every popped transaction against the oldest predicted frame
  always @(posedge clk) begin
    frame_result_t want;
    if (rst_n && pop && !empty) begin
      if (frames_due.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none, actual id %h len %h data %h match %h",
                 $time, out_frame_id, out_frame_length, out_frame_data, out_match_mask);
      end else begin
        want = frames_due.pop_front();
        check_field("frame_id", want.id, out_frame_id);
        check_field("frame_length", want.length, out_frame_length);
        check_field("frame_data", want.data, out_frame_data);
        check_field("match_mask", want.match_bits, out_match_mask);
      end
    end
  end

  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else if (rx_gaps_on) begin
      pop <= ($urandom_range(99) >= 35);
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    push           = 1'b0;
    in_rx_byte     = 8'h00;
    pop            = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    hold_req       = 1'b0;
    hold_left      = 0;
    tx_gaps_on     = 1'b1;
    rx_gaps_on     = 1'b1;
    mismatch_count = 0;
    bytes_sent     = 0;
    cycle_count    = 0;
    parse_ph       = PH_HUNT;
    bytes_due      = '0;
    frame_len      = '0;
    frame_ident    = '0;
    filt_count     = '0;
    foreach (frame_bytes[k]) frame_bytes[k] = 8'h00;
    foreach (filt_entry[e]) filt_entry[e] = '0;

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_frames();
    test_filter_settings();
    test_no_idle_stretch();
    test_backpressure();
    test_random_stream();
    drain_results();

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/csdf_pkg.sv
design/csdf_parser.sv
design/csdf_queue.sv
design/csdf_filter.sv
design/can_serial_frame_deframer_filter_core.sv
sim/tb_can_serial_frame_deframer_filter_core.sv
